// File: design/assert_macros.svh
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define ASSERT_IMPL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  `ASSERT_IMPL(lbl, !(cond), msg)

`endif

// File: design/trls_pkg.sv
// Shared constants, types and helpers of the terrain scanline generator.
package trls_pkg;

  localparam int LineWidth = 128;
  localparam int LineCount = 240;
  localparam int RomDepth  = 2048;

  localparam int ColW    = $clog2(LineWidth);
  localparam int RowW    = $clog2(LineCount);
  localparam int RomIdxW = $clog2(RomDepth);

  // Fixed field widths of the request and result ports
  localparam int AddrW  = 11;
  localparam int DataW  = 8;
  localparam int ScrollW = 8;
  localparam int ColorW = 3;
  localparam int XW     = 7;
  localparam int YW     = 8;

  localparam int RunW      = 6;
  localparam int RunFieldW = 5;
  localparam logic [RunW-1:0] RunBase = RunW'(32);
  localparam int LineStep      = 16;
  localparam int LineStepShift = $clog2(LineStep);

  localparam int OutQDepth = 4;
  localparam int OutQPtrW  = $clog2(OutQDepth);
  localparam int OutQCntW  = $clog2(OutQDepth + 1);

  typedef enum logic {
    CmdLoad  = 1'b0,
    CmdPixel = 1'b1
  } cmd_e;

  typedef struct packed {
    logic              pixel_valid;
    logic [ColorW-1:0] pixel_color;
    logic [XW-1:0]     pixel_x;
    logic [YW-1:0]     pixel_y;
    logic              line_end;
    logic              frame_end;
  } result_t;

  // Stage-two record of one accepted request
  typedef struct packed {
    logic            is_pixel;
    logic            fetch;
    logic [ColW-1:0] col;
    logic [RowW-1:0] row;
    logic            last_col;
    logic            last_row;
  } stage_t;

  function automatic logic [RomIdxW-1:0] rom_idx(input logic [AddrW-1:0] addr);
    rom_idx = RomIdxW'(addr);
  endfunction

endpackage

// File: design/trls_ram.sv
// Generic single-write, single-read RAM with registered read data.
module trls_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/trls_outq.sv
// Small result queue that decouples the pixel pipeline from the output channel.
`include "assert_macros.svh"

module trls_outq (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  trls_pkg::result_t        push_data_i,
  output logic [trls_pkg::OutQCntW-1:0] level_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output trls_pkg::result_t        out_data_o
);
  import trls_pkg::*;

  result_t               mem_q [OutQDepth];
  logic [OutQPtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [OutQPtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [OutQCntW-1:0]   count_q, count_d;
  logic                  pop;

  assign pop = out_valid_o && out_ready_i;

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + OutQPtrW'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + OutQPtrW'(1) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop) begin
      count_d = count_q + OutQCntW'(1);
    end else if (!push_i && pop) begin
      count_d = count_q - OutQCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign out_valid_o = (count_q != '0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign level_o     = count_q;

  `ASSERT_NEVER(a_outq_overflow, push_i && !pop && (count_q == OutQCntW'(OutQDepth)), "result queue overflow")
  `ASSERT_IMPL(a_outq_ptr_gap, (count_q == '0) || (count_q == OutQCntW'(OutQDepth)) || (wr_ptr_q != rd_ptr_q), "queue pointers disagree with level")

endmodule

// File: design/terrain_run_length_scanline.sv
// Top level: run-length terrain raster generator with ROM load port.
//
//   channel  | handshake              | payload
//   ---------+------------------------+----------------------------------------------
//   request  | in_valid_i/in_ready_o  | command, rom_address, rom_data, scroll
//   result   | out_valid_o/out_ready_i| pixel_valid, pixel_color, pixel_x, pixel_y,
//            |                        | line_end, frame_end
//
// One request per clock while in_ready_o is high; each result passes through the ROM
// read in the accept cycle, the run update in the next, then the result queue.
// The run length loop closes through the ROM read data: the next pixel's fetch
// decision uses the run count computed from the byte read for the request in stage two.
// Reset clears raster, run and queue state; the ROM contents are undefined until loaded.
// Requests stall when the queued results plus the request in stage two reach four.
`include "assert_macros.svh"

module terrain_run_length_scanline (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          command_i,
  input  logic [trls_pkg::AddrW-1:0]    rom_address_i,
  input  logic [trls_pkg::DataW-1:0]    rom_data_i,
  input  logic [trls_pkg::ScrollW-1:0]  scroll_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          pixel_valid_o,
  output logic [trls_pkg::ColorW-1:0]   pixel_color_o,
  output logic [trls_pkg::XW-1:0]       pixel_x_o,
  output logic [trls_pkg::YW-1:0]       pixel_y_o,
  output logic                          line_end_o,
  output logic                          frame_end_o
);
  import trls_pkg::*;

  // Raster front end
  logic [ColW-1:0]  column_q, column_d;
  logic [RowW-1:0]  row_q, row_d;
  logic [AddrW-1:0] fetch_addr_q, fetch_addr_d;

  // Run state, updated in stage two
  logic [RunW-1:0]   run_q, run_d;
  logic [ColorW-1:0] color_q, color_d;

  logic   s2_valid_q;
  stage_t s2_q, s2_d;

  logic               acc, is_pix, col0, last_col, last_row, fetch, rd_en;
  logic [RunW-1:0]    run_eff, run_base, run_next;
  logic [RowW:0]      row_inc;
  logic [AddrW-1:0]   line_addr, rd_addr;
  logic [DataW-1:0]   rdata;
  logic [ColorW-1:0]  color_next;
  logic [OutQCntW-1:0] q_level;
  result_t            res, out_res;

  assign acc    = in_valid_i && in_ready_o;
  assign is_pix = (cmd_e'(command_i) == CmdPixel);

  // Hold one slot back for the request sitting in stage two
  assign in_ready_o = ((OutQCntW + 1)'(q_level) + (OutQCntW + 1)'(s2_valid_q))
                      < (OutQCntW + 1)'(OutQDepth);

  // Stage two: fold the fetched byte into the run state
  always_comb begin
    run_base   = s2_q.fetch ? (RunBase - RunW'(rdata[RunFieldW-1:0])) : run_q;
    run_next   = s2_q.last_col ? '0 : (run_base - RunW'(1));
    color_next = s2_q.fetch ? rdata[DataW-1 -: ColorW] : color_q;
    run_d      = run_q;
    color_d    = color_q;
    if (s2_valid_q && s2_q.is_pixel) begin
      run_d   = run_next;
      color_d = color_next;
    end
  end

  // Front end: decide the fetch and issue the ROM read
  always_comb begin
    run_eff   = (s2_valid_q && s2_q.is_pixel) ? run_next : run_q;
    col0      = (column_q == '0);
    last_col  = (column_q == ColW'(LineWidth - 1));
    last_row  = (row_q == RowW'(LineCount - 1));
    fetch     = col0 || (run_eff == '0);
    row_inc   = {1'b0, row_q} + (RowW + 1)'(1);
    line_addr = (AddrW'(scroll_i) + AddrW'(row_inc[RowW:1])) << LineStepShift;
    rd_addr   = col0 ? line_addr : fetch_addr_q;
    rd_en     = acc && is_pix && fetch;

    fetch_addr_d = rd_en ? rd_addr + AddrW'(1) : fetch_addr_q;
    column_d     = column_q;
    row_d        = row_q;
    if (acc && is_pix) begin
      if (last_col) begin
        column_d = '0;
        row_d    = last_row ? '0 : row_q + RowW'(1);
      end else begin
        column_d = column_q + ColW'(1);
      end
    end

    s2_d.is_pixel = is_pix;
    s2_d.fetch    = fetch;
    s2_d.col      = column_q;
    s2_d.row      = row_q;
    s2_d.last_col = last_col;
    s2_d.last_row = last_row;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q     <= '0;
      row_q        <= '0;
      fetch_addr_q <= '0;
      run_q        <= '0;
      color_q      <= '0;
      s2_valid_q   <= 1'b0;
    end else begin
      column_q     <= column_d;
      row_q        <= row_d;
      fetch_addr_q <= fetch_addr_d;
      run_q        <= run_d;
      color_q      <= color_d;
      s2_valid_q   <= acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s2_q <= s2_d;
    end
  end

  trls_ram #(
    .Width (DataW),
    .Depth (RomDepth)
  ) u_rom (
    .clk_i   (clk_i),
    .we_i    (acc && !is_pix),
    .waddr_i (rom_idx(rom_address_i)),
    .wdata_i (rom_data_i),
    .re_i    (rd_en),
    .raddr_i (rom_idx(rd_addr)),
    .rdata_o (rdata)
  );

  // Load acknowledges carry all-zero fields
  always_comb begin
    res = '0;
    if (s2_q.is_pixel) begin
      res.pixel_valid = 1'b1;
      res.pixel_color = color_next;
      res.pixel_x     = XW'(s2_q.col);
      res.pixel_y     = YW'(s2_q.row);
      res.line_end    = s2_q.last_col;
      res.frame_end   = s2_q.last_col && s2_q.last_row;
    end
  end

  trls_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s2_valid_q),
    .push_data_i (res),
    .level_o     (q_level),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_res)
  );

  assign pixel_valid_o = out_res.pixel_valid;
  assign pixel_color_o = out_res.pixel_color;
  assign pixel_x_o     = out_res.pixel_x;
  assign pixel_y_o     = out_res.pixel_y;
  assign line_end_o    = out_res.line_end;
  assign frame_end_o   = out_res.frame_end;

  `ASSERT_IMPL(a_line_end_clears_run,
               s2_valid_q && s2_q.is_pixel && s2_q.last_col |=> (run_q == '0),
               "run survives a line end")
  `ASSERT_IMPL(a_line_start_fetch,
               acc && is_pix && col0 |=> s2_valid_q && s2_q.fetch,
               "line start without fetch")
  `ASSERT_IMPL(a_load_keeps_raster,
               acc && !is_pix |=> $stable(column_q) && $stable(fetch_addr_q),
               "load moved the raster")

endmodule

// File: bench/terrain_run_length_scanline_tb.sv
// Self-checking testbench for the run-length terrain scanline generator.
module terrain_run_length_scanline_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import trls_pkg::*;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic               command_i;
  logic [AddrW-1:0]   rom_address_i;
  logic [DataW-1:0]   rom_data_i;
  logic [ScrollW-1:0] scroll_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic               pixel_valid_o;
  logic [ColorW-1:0]  pixel_color_o;
  logic [XW-1:0]      pixel_x_o;
  logic [YW-1:0]      pixel_y_o;
  logic               line_end_o;
  logic               frame_end_o;

  // Raster model state
  logic [DataW-1:0]   rom_image [RomDepth];
  bit                 rom_loaded [RomDepth];
  logic [XW-1:0]      ras_col;
  logic [YW-1:0]      ras_row;
  logic [RunW-1:0]    run_left;
  logic [ColorW-1:0]  run_color;
  logic [AddrW-1:0]   fetch_addr;

  result_t awaited[$];
  result_t head;
  int      errors;
  bit      src_idle;
  bit      sink_idle;
  int      hold_cycles;

  terrain_run_length_scanline uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .command_i     (command_i),
    .rom_address_i (rom_address_i),
    .rom_data_i    (rom_data_i),
    .scroll_i      (scroll_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pixel_valid_o (pixel_valid_o),
    .pixel_color_o (pixel_color_o),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .line_end_o    (line_end_o),
    .frame_end_o   (frame_end_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [AddrW-1:0] line_base(input logic [ScrollW-1:0] scr);
    return AddrW'(LineStep * scr + LineStep * ((ras_row + 1) / 2));
  endfunction

  // Tell whether the next pixel request reads the ROM, and from where.
  function automatic bit tick_fetches(input logic [ScrollW-1:0] scr,
                                      output logic [AddrW-1:0] addr);
    addr = fetch_addr;
    if (ras_col == '0) begin
      addr = line_base(scr);
      return 1'b1;
    end
    return run_left == '0;
  endfunction

  // Advance the raster model by one request and return the result it yields.
  function automatic result_t apply_request(input cmd_e cmd, input logic [AddrW-1:0] addr,
                                            input logic [DataW-1:0] data,
                                            input logic [ScrollW-1:0] scr);
    result_t          r;
    logic [DataW-1:0] rom_byte;
    logic             last_col;
    logic             last_row;
    r = '0;
    if (cmd == CmdLoad) begin
      rom_image[addr] = data;
      rom_loaded[addr] = 1'b1;
      return r;
    end
    if (ras_col == '0) begin
      fetch_addr = line_base(scr);
      run_left = '0;
    end
    if (run_left == '0) begin
      rom_byte = rom_image[fetch_addr];
      run_color = rom_byte[DataW-1 -: ColorW];
      run_left = RunBase - RunW'(rom_byte[RunFieldW-1:0]);
      fetch_addr = fetch_addr + AddrW'(1);
    end
    last_col = (ras_col == XW'(LineWidth - 1));
    last_row = (ras_row == YW'(LineCount - 1));
    r.pixel_valid = 1'b1;
    r.pixel_color = run_color;
    r.pixel_x     = ras_col;
    r.pixel_y     = ras_row;
    r.line_end    = last_col;
    r.frame_end   = last_col && last_row;
    run_left = run_left - RunW'(1);
    if (last_col) begin
      // drop the open run; the next line starts with a fresh fetch
      ras_col = '0;
      run_left = '0;
      ras_row = last_row ? '0 : ras_row + YW'(1);
    end else begin
      ras_col = ras_col + XW'(1);
    end
    return r;
  endfunction

  task automatic send_request(input cmd_e cmd, input logic [AddrW-1:0] addr,
                              input logic [DataW-1:0] data, input logic [ScrollW-1:0] scr);
    if (src_idle && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    command_i     <= cmd;
    rom_address_i <= addr;
    rom_data_i    <= data;
    scroll_i      <= scr;
    do @(posedge clk_i); while (!in_ready_o);
    awaited.push_back(apply_request(cmd, addr, data, scr));
  endtask

  // Load the ROM byte a pixel is about to read if it was never written, then send the pixel.
  task automatic send_pixel(input logic [ScrollW-1:0] scr, input logic [DataW-1:0] fill);
    logic [AddrW-1:0] addr;
    if (tick_fetches(scr, addr) && !rom_loaded[addr])
      send_request(CmdLoad, addr, fill, ScrollW'($urandom));
    send_request(CmdPixel, AddrW'($urandom), DataW'($urandom), scr);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (awaited.size() != 0);
  endtask

  // Line 0 at full scroll starts near the top of the ROM; single-pixel runs walk
  // the fetch address through the last byte and around to byte 0.
  task automatic rom_wrap_test();
    send_request(CmdLoad, '0, 8'h00, 8'h00);
    send_request(CmdLoad, AddrW'(RomDepth - 1), 8'hFF, 8'hFF);
    for (int i = 0; i < 18; i++)
      send_pixel(i == 0 ? 8'hFF : ScrollW'($urandom), {3'(i), 5'h1F});
  endtask

  // Paint through two line ends, clipping the runs that are still open there.
  task automatic line_wrap_test();
    int remaining;
    logic [ScrollW-1:0] scr;
    src_idle = 1'b0;
    sink_idle = 1'b0;
    remaining = 2 * LineWidth - int'(ras_col);
    repeat (remaining) begin
      case (ras_row[1:0])
        2'd0:    scr = '0;
        2'd1:    scr = '1;
        default: scr = ScrollW'($urandom);
      endcase
      send_pixel(scr, DataW'($urandom));
    end
  endtask

  task automatic random_request();
    if ($urandom_range(0, 9) < 3)
      send_request(CmdLoad, AddrW'($urandom), DataW'($urandom), ScrollW'($urandom));
    else
      send_pixel(ScrollW'($urandom), DataW'($urandom));
  endtask

  // Hold the result side long enough to fill the block, then let it empty out.
  task automatic backpressure_test();
    src_idle = 1'b0;
    sink_idle = 1'b0;
    hold_cycles = 300;
    repeat (40) random_request();
    drain();
  endtask

  task automatic random_test();
    for (int chunk = 0; chunk < 10; chunk++) begin
      src_idle  = chunk < 8 && $urandom_range(0, 3) != 0;
      sink_idle = chunk < 8 && $urandom_range(0, 3) != 0;
      repeat (40) random_request();
    end
  endtask

  initial begin
    rst_ni        <= 1'b0;
    in_valid_i    <= 1'b0;
    command_i     <= CmdLoad;
    rom_address_i <= '0;
    rom_data_i    <= '0;
    scroll_i      <= '0;
    ras_col       = '0;
    ras_row       = '0;
    run_left      = '0;
    run_color     = '0;
    fetch_addr    = '0;
    errors        = 0;
    src_idle      = 1'b0;
    sink_idle     = 1'b0;
    hold_cycles   = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    rom_wrap_test();
    line_wrap_test();
    backpressure_test();
    random_test();
    drain();
    repeat (10) @(posedge clk_i);
    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  initial begin
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        out_ready_i <= 1'b0;
        repeat (hold_cycles) @(posedge clk_i);
        hold_cycles = 0;
        out_ready_i <= 1'b1;
      end else if (sink_idle && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited.size() == 0) begin
        $error("result with no request pending");
        errors++;
      end else begin
        head = awaited.pop_front();
        check_field("pixel_valid", 32'(head.pixel_valid), 32'(pixel_valid_o));
        check_field("pixel_color", 32'(head.pixel_color), 32'(pixel_color_o));
        check_field("pixel_x", 32'(head.pixel_x), 32'(pixel_x_o));
        check_field("pixel_y", 32'(head.pixel_y), 32'(pixel_y_o));
        check_field("line_end", 32'(head.line_end), 32'(line_end_o));
        check_field("frame_end", 32'(head.frame_end), 32'(frame_end_o));
      end
    end
  end

  initial begin
    #4_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
